FILE: hw/rtl/mseu_pkg.sv
`timescale 1ns / 1ps
package mseu_pkg;

  localparam int unsigned DataMemBytes = 1024;
  localparam int unsigned DmAw = $clog2(DataMemBytes);

  localparam logic [5:0] K_ADD = 6'd0, K_ADDU = 6'd1, K_SUB = 6'd2, K_AND = 6'd3,
    K_OR = 6'd4, K_XOR = 6'd5, K_NOR = 6'd6, K_NAND = 6'd7, K_SLT = 6'd8,
    K_SLL = 6'd9, K_SRL = 6'd10, K_SRA = 6'd11, K_JR = 6'd12, K_MULT = 6'd13,
    K_MULTU = 6'd14, K_MFHI = 6'd15, K_MFLO = 6'd16, K_ADDI = 6'd17,
    K_ADDIU = 6'd18, K_LW = 6'd19, K_LH = 6'd20, K_LHU = 6'd21, K_LB = 6'd22,
    K_LBU = 6'd23, K_SW = 6'd24, K_SH = 6'd25, K_SB = 6'd26, K_LUI = 6'd27,
    K_ANDI = 6'd28, K_ORI = 6'd29, K_NORI = 6'd30, K_SLTI = 6'd31,
    K_BEQ = 6'd32, K_BNE = 6'd33, K_BGTZ = 6'd34, K_J = 6'd35, K_JAL = 6'd36;

  typedef struct packed {
    logic [5:0]  kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [25:0] tgt;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        zero_err;
    logic        ovf_err;
    logic        hilo_err;
    logic        range_err;
    logic        mis_err;
    logic        halted;
  } result_t;

endpackage

FILE: hw/rtl/mseu_front.sv
`timescale 1ns / 1ps
// Two-entry word queue between the input channel and the execute engine.
module mseu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mseu_pkg::instr_t in_word_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output mseu_pkg::instr_t q_word_o
);
  mseu_pkg::instr_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

FILE: hw/rtl/mseu_back.sv
`timescale 1ns / 1ps
// Execute engine: read cycle, execute/writeback cycle, then output register.
module mseu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  mseu_pkg::instr_t  q_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mseu_pkg::result_t out_res_o
);
  localparam int unsigned Aw = mseu_pkg::DmAw;
  localparam int unsigned Words = mseu_pkg::DataMemBytes / 4;
  localparam int unsigned Wa = Aw - 2;

  // phase: 0 idle, 1 read, 2 execute, 3 multiply finish
  localparam logic [1:0] PH_IDLE = 2'd0, PH_RD = 2'd1, PH_EX = 2'd2, PH_MUL = 2'd3;
  localparam logic [1:0] CL_IDLE = 2'd0, CL_RUN = 2'd1;

  logic [1:0] ph_q;
  logic [1:0] cl_q;
  logic [Wa:0] clr_q;
  mseu_pkg::instr_t ins_q;

  logic [31:0] gpr_q [32];
  logic [31:0] dmem_q [Words];
  logic [31:0] a_q, b_q, dword_q;
  logic [31:0] hi_q, lo_q, pc_q;
  logic        mpend_q, rseen_q;
  logic        ov_q;
  mseu_pkg::result_t res_q, res_d;
  logic [63:0] prod_q;
  mseu_pkg::result_t mres_q;

  logic [31:0] addr, simm;
  logic [32:0] sum33;

  logic        dm_we;
  logic [Wa-1:0] dm_wa;
  logic [31:0] dm_wd;
  logic [3:0]  dm_be;
  logic        gp_we;
  logic [4:0]  gp_wa;
  logic [31:0] gp_wd;
  logic        mp_d, rs_d;
  logic        is_mul;
  logic        ov_set;
  logic [31:0] hi_fix;

  logic busy_out;
  assign busy_out = ov_q && out_stall_i;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;

  assign q_pop_o = (ph_q == PH_IDLE) && q_valid_i && (cl_q == CL_IDLE);

  assign is_mul = ins_q.kind inside {mseu_pkg::K_MULT, mseu_pkg::K_MULTU};
  assign ov_set = ((ph_q == PH_EX) && !busy_out && !is_mul) || (ph_q == PH_MUL);

  // signed high half: subtract the other operand for each negative one
  assign hi_fix = prod_q[63:32]
                - ((ins_q.kind == mseu_pkg::K_MULT && a_q[31]) ? b_q : 32'd0)
                - ((ins_q.kind == mseu_pkg::K_MULT && b_q[31]) ? a_q : 32'd0);

  // combinational read of registered operands
  assign simm = {{16{ins_q.imm[15]}}, ins_q.imm};
  assign addr = a_q + simm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; cl_q <= CL_RUN; clr_q <= '0; ov_q <= 1'b0;
      pc_q <= '0; hi_q <= '0; lo_q <= '0; mpend_q <= 1'b0; rseen_q <= 1'b0;
    end else begin
      if (cl_q == CL_RUN) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == (Wa+1)'(Words - 1)) cl_q <= CL_IDLE;
      end
      if (ov_set) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (ph_q)
        PH_IDLE: if (q_pop_o) ph_q <= PH_RD;
        PH_RD:   ph_q <= PH_EX;
        PH_EX: begin
          if (!busy_out) begin
            if (is_mul) begin
              ph_q <= PH_MUL;
            end else begin
              ph_q <= PH_IDLE; pc_q <= res_d.next_pc;
            end
            mpend_q <= mp_d; rseen_q <= rs_d;
          end
        end
        PH_MUL: begin
          ph_q <= PH_IDLE; pc_q <= mres_q.next_pc;
          hi_q <= hi_fix; lo_q <= prod_q[31:0];
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  // operand and word reads
  always_ff @(posedge clk_i) begin
    if (q_pop_o) ins_q <= q_word_i;
    if (ph_q == PH_IDLE) begin
      a_q <= gpr_q[q_word_i.rs];
      b_q <= gpr_q[q_word_i.rt];
    end
    if (ph_q == PH_RD) dword_q <= dmem_q[addr[Aw-1:2]];
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr_q[i] <= '0;
    end else if (gp_we) begin
      gpr_q[gp_wa] <= gp_wd;
    end
  end

  // data memory words, big-endian byte lanes; cleared by a sweep after reset
  always_ff @(posedge clk_i) begin
    if (cl_q == CL_RUN) dmem_q[clr_q[Wa-1:0]] <= '0;
    else if (dm_we) begin
      for (int j = 0; j < 4; j++)
        if (dm_be[j]) dmem_q[dm_wa][8*j +: 8] <= dm_wd[8*j +: 8];
    end
  end

  // unsigned product registered before HI/LO
  always_ff @(posedge clk_i) begin
    if (ph_q == PH_EX && !busy_out) begin
      prod_q <= {32'd0, a_q} * {32'd0, b_q};
      mres_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_EX && !busy_out && !is_mul) res_q <= res_d;
    else if (ph_q == PH_MUL) res_q <= mres_q;
  end

  assign gp_we = (ph_q == PH_EX) && !busy_out && res_d.wr_en;
  assign gp_wa = res_d.wr_idx;
  assign gp_wd = res_d.wr_val;

  always_comb begin
    logic [31:0] pc4, br, v, s, jt;
    logic [4:0]  widx;
    logic        wen, fz, ok, ld, st;
    logic [2:0]  size;
    logic [15:0] hw;
    logic [7:0]  by;
    pc4 = pc_q + 32'd4;
    br = pc4 + {simm[29:0], 2'b00};
    jt = {pc4[31:28], ins_q.tgt, 2'b00};
    v = '0; s = '0; widx = ins_q.rd; wen = 1'b0; fz = 1'b1;
    ld = 1'b0; st = 1'b0; size = 3'd4; ok = 1'b1;
    hw = '0; by = '0;
    sum33 = '0;
    res_d = '0;
    res_d.next_pc = pc4;
    mp_d = mpend_q; rs_d = rseen_q;
    dm_we = 1'b0; dm_wa = addr[Aw-1:2]; dm_wd = '0; dm_be = '0;
    case (ins_q.kind)
      mseu_pkg::K_ADD: begin
        s = a_q + b_q; v = s; wen = 1'b1;
        res_d.ovf_err = ~(a_q[31] ^ b_q[31]) & (a_q[31] ^ s[31]);
      end
      mseu_pkg::K_ADDU: begin v = a_q + b_q; wen = 1'b1; end
      mseu_pkg::K_SUB: begin
        s = a_q - b_q; v = s; wen = 1'b1;
        res_d.ovf_err = (a_q[31] ^ b_q[31]) & (a_q[31] ^ s[31]);
      end
      mseu_pkg::K_AND:  begin v = a_q & b_q; wen = 1'b1; end
      mseu_pkg::K_OR:   begin v = a_q | b_q; wen = 1'b1; end
      mseu_pkg::K_XOR:  begin v = a_q ^ b_q; wen = 1'b1; end
      mseu_pkg::K_NOR:  begin v = ~(a_q | b_q); wen = 1'b1; end
      mseu_pkg::K_NAND: begin v = ~(a_q & b_q); wen = 1'b1; end
      mseu_pkg::K_SLT:  begin v = {31'd0, $signed(a_q) < $signed(b_q)}; wen = 1'b1; end
      mseu_pkg::K_SLL: begin
        v = b_q << ins_q.sh; wen = 1'b1; fz = (ins_q.rt != 5'd0) || (ins_q.sh != 5'd0);
      end
      mseu_pkg::K_SRL: begin v = b_q >> ins_q.sh; wen = 1'b1; end
      mseu_pkg::K_SRA: begin v = $unsigned($signed(b_q) >>> ins_q.sh); wen = 1'b1; end
      mseu_pkg::K_JR: res_d.next_pc = a_q;
      mseu_pkg::K_MULT, mseu_pkg::K_MULTU: begin
        if (mpend_q && rseen_q) rs_d = 1'b0;
        else if (mpend_q) res_d.hilo_err = 1'b1;
        else mp_d = 1'b1;
      end
      mseu_pkg::K_MFHI: begin v = hi_q; wen = 1'b1; rs_d = 1'b1; end
      mseu_pkg::K_MFLO: begin v = lo_q; wen = 1'b1; rs_d = 1'b1; end
      mseu_pkg::K_ADDI: begin
        s = a_q + simm; v = s; wen = 1'b1; widx = ins_q.rt;
        res_d.ovf_err = ~(a_q[31] ^ simm[31]) & (a_q[31] ^ s[31]);
      end
      mseu_pkg::K_ADDIU: begin v = a_q + simm; wen = 1'b1; widx = ins_q.rt; end
      mseu_pkg::K_LW, mseu_pkg::K_SW: begin size = 3'd4; ld = ins_q.kind == mseu_pkg::K_LW;
        st = !ld; end
      mseu_pkg::K_LH, mseu_pkg::K_LHU, mseu_pkg::K_SH: begin size = 3'd2;
        ld = ins_q.kind != mseu_pkg::K_SH; st = !ld; end
      mseu_pkg::K_LB, mseu_pkg::K_LBU, mseu_pkg::K_SB: begin size = 3'd1;
        ld = ins_q.kind != mseu_pkg::K_SB; st = !ld; end
      mseu_pkg::K_LUI:  begin v = {ins_q.imm, 16'd0}; wen = 1'b1; widx = ins_q.rt; end
      mseu_pkg::K_ANDI: begin v = a_q & {16'd0, ins_q.imm}; wen = 1'b1; widx = ins_q.rt; end
      mseu_pkg::K_ORI:  begin v = a_q | {16'd0, ins_q.imm}; wen = 1'b1; widx = ins_q.rt; end
      mseu_pkg::K_NORI: begin v = ~(a_q | {16'd0, ins_q.imm}); wen = 1'b1; widx = ins_q.rt; end
      mseu_pkg::K_SLTI: begin v = {31'd0, $signed(a_q) < $signed(simm)}; wen = 1'b1;
        widx = ins_q.rt; end
      mseu_pkg::K_BEQ: if (a_q == b_q) res_d.next_pc = br;
      mseu_pkg::K_BNE: if (a_q != b_q) res_d.next_pc = br;
      mseu_pkg::K_BGTZ: if (a_q != '0 && !a_q[31]) res_d.next_pc = br;
      mseu_pkg::K_J: res_d.next_pc = jt;
      mseu_pkg::K_JAL: begin res_d.next_pc = jt; v = pc4; wen = 1'b1; widx = 5'd31; end
      default: res_d.halted = 1'b1;
    endcase
    if (ld || st) begin
      widx = ins_q.rt;
      res_d.ovf_err = ~(a_q[31] ^ simm[31]) & (a_q[31] ^ addr[31]);
      sum33 = {1'b0, addr} + 33'(size) - 33'd1;
      if (sum33 >= 33'(mseu_pkg::DataMemBytes)) begin
        res_d.range_err = 1'b1; ok = 1'b0;
      end
      if ((size == 3'd4 && addr[1:0] != 2'b00) || (size == 3'd2 && addr[0])) begin
        res_d.mis_err = 1'b1; ok = 1'b0;
      end
      if (!ok) begin
        res_d.halted = 1'b1;
        if (ld && ins_q.rt == 5'd0) res_d.zero_err = 1'b1;
      end else if (ld) begin
        wen = 1'b1;
        hw = addr[1] ? dword_q[15:0] : dword_q[31:16];
        case (addr[1:0])
          2'd0: by = dword_q[31:24];
          2'd1: by = dword_q[23:16];
          2'd2: by = dword_q[15:8];
          default: by = dword_q[7:0];
        endcase
        case (ins_q.kind)
          mseu_pkg::K_LW:  v = dword_q;
          mseu_pkg::K_LH:  v = {{16{hw[15]}}, hw};
          mseu_pkg::K_LHU: v = {16'd0, hw};
          mseu_pkg::K_LB:  v = {{24{by[7]}}, by};
          default:         v = {24'd0, by};
        endcase
      end else begin
        dm_we = (ph_q == PH_EX) && !busy_out;
        case (size)
          3'd4: begin dm_wd = b_q; dm_be = 4'hf; end
          3'd2: begin dm_wd = {2{b_q[15:0]}}; dm_be = addr[1] ? 4'h3 : 4'hc; end
          default: begin
            dm_wd = {4{b_q[7:0]}};
            dm_be = 4'b1000 >> addr[1:0];
          end
        endcase
      end
    end
    if (wen) begin
      if (widx == 5'd0) begin
        v = '0;
        if (fz) res_d.zero_err = 1'b1;
      end
      res_d.wr_en = 1'b1; res_d.wr_idx = widx; res_d.wr_val = v;
    end
  end
endmodule

FILE: hw/rtl/mips_subset_execute_unit_top.sv
`timescale 1ns / 1ps
// MIPS subset execute unit.
// Input channel: one decoded instruction word per handshake (in_valid_i high,
// in_stall_o low at a rising edge). Output channel: one result word per
// instruction, taken when out_valid_o is high and out_stall_i low.
// Front: a two-entry queue holds incoming words so the sender rarely waits.
// Back: the cycle that takes a word from the queue reads the register
// operands, the next reads the data memory word, then the execute phase,
// which waits while a stalled result is held, executes and writes back into
// the output register; mult and multu do that in an added multiply phase,
// which also writes the registered product into HI/LO. A new item is taken
// from the queue only once the last one has left the execute or multiply phase.
// Reset: registers, PC, HI/LO clear at once; the data memory is then swept
// to zero one word a cycle (DataMemBytes/4 = 256 words), during which items
// queue but none execute.
// A stalled result holds its value; execution waits until the word is taken.
module mips_subset_execute_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  kind_i,
  input  logic [4:0]  src_reg_i,
  input  logic [4:0]  tgt_reg_i,
  input  logic [4:0]  dst_reg_i,
  input  logic [4:0]  shift_amount_i,
  input  logic [15:0] imm16_i,
  input  logic [25:0] jump_target_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        wr_enable_o,
  output logic [4:0]  wr_index_o,
  output logic [31:0] wr_value_o,
  output logic        zero_write_err_o,
  output logic        overflow_err_o,
  output logic        hilo_overwrite_err_o,
  output logic        mem_range_err_o,
  output logic        misaligned_err_o,
  output logic        halted_o
);
  mseu_pkg::instr_t  in_word, q_word;
  mseu_pkg::result_t res;
  logic q_valid, q_pop;

  // pack the incoming fields into one word
  assign in_word = '{kind: kind_i, rs: src_reg_i, rt: tgt_reg_i, rd: dst_reg_i,
                     sh: shift_amount_i, imm: imm16_i, tgt: jump_target_i};

  mseu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i(in_word),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  mseu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid_o, .out_stall_i, .out_res_o(res)
  );

  assign next_pc_o            = res.next_pc;
  assign wr_enable_o          = res.wr_en;
  assign wr_index_o           = res.wr_idx;
  assign wr_value_o           = res.wr_val;
  assign zero_write_err_o     = res.zero_err;
  assign overflow_err_o       = res.ovf_err;
  assign hilo_overwrite_err_o = res.hilo_err;
  assign mem_range_err_o      = res.range_err;
  assign misaligned_err_o     = res.mis_err;
  assign halted_o             = res.halted;
endmodule

FILE: hw/rtl/mseu_checker.sv
`timescale 1ns / 1ps
module mseu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        wr_enable_o,
  input logic [4:0]  wr_index_o,
  input logic [31:0] wr_value_o,
  input logic        mem_range_err_o,
  input logic        misaligned_err_o,
  input logic        halted_o
);
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(wr_value_o))
    else $error("result word dropped while stalled");
  ap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wr_enable_o && wr_index_o == 5'd0 |-> wr_value_o == 32'd0)
    else $error("register zero written non-zero");
  ap_mem_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mem_range_err_o || misaligned_err_o) |-> halted_o)
    else $error("bad access without halt");
  ap_bad_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mem_range_err_o || misaligned_err_o) |-> !wr_enable_o)
    else $error("bad access wrote a register");
endmodule

bind mips_subset_execute_unit_top mseu_checker u_chk (.*);
